// ===== rtl/core/pn_code_generator_macros.svh =====
// Assertion macros for the checker file of the PN code generator.
// No dependencies; include by bare file name where assertions are written.
`ifndef PN_CODE_GENERATOR_MACROS_SVH
`define PN_CODE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/png_pkg.sv =====
// Shared types, register map and tap table for the PN code generator.
// No dependencies; used by scoped names from the core.
package png_pkg;

  localparam int unsigned MaxStages = 17;
  localparam int unsigned MaxCodes  = 17;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 4;

  typedef logic [MaxStages-1:0] stage_t;
  typedef logic [CodeW-1:0]     code_t;
  typedef logic [DataW-1:0]     data_t;

  // Register indexes; register i sits at byte address 4*i
  typedef enum logic [1:0] {
    RegCodeNumber = 2'd0,
    RegLowValue   = 2'd1,
    RegHighValue  = 2'd2
  } reg_idx_e;

  localparam code_t CodeReset = code_t'(10);
  localparam data_t LowReset  = data_t'(0);
  localparam data_t HighReset = data_t'(1);

  // Clamp the code number into 1..MaxCodes
  function automatic code_t eff_code(input code_t code);
    code_t c;
    c = code;
    if (c == '0) begin
      c = code_t'(1);
    end else if (c > code_t'(MaxCodes)) begin
      c = code_t'(MaxCodes);
    end
    return c;
  endfunction

  // Feedback tap mask; bit k marks stage k+1 as a tap
  function automatic stage_t tap_mask(input code_t code);
    stage_t m;
    unique case (code)
      5'd1:    m = 17'h00001;
      5'd2:    m = 17'h00003;
      5'd3:    m = 17'h00006;
      5'd4:    m = 17'h0000C;
      5'd5:    m = 17'h00014;
      5'd6:    m = 17'h00030;
      5'd7:    m = 17'h00060;
      5'd8:    m = 17'h000C6;
      5'd9:    m = 17'h00110;
      5'd10:   m = 17'h00240;
      5'd11:   m = 17'h00500;
      5'd12:   m = 17'h00990;
      5'd13:   m = 17'h01B00;
      5'd14:   m = 17'h03006;
      5'd15:   m = 17'h06000;
      5'd16:   m = 17'h0B400;
      default: m = 17'h12000;
    endcase
    return m;
  endfunction

  // Index of the last chip in a period: 2^n-2, which is zero for code 1
  function automatic stage_t last_index(input code_t code);
    logic [MaxStages:0] len;
    len = ({{MaxStages{1'b0}}, 1'b1}) << code;
    return stage_t'(len - (MaxStages+1)'(2));
  endfunction

endpackage

// ===== rtl/core/pn_code_generator.sv =====
// PN code generator top level: config registers, shift register, chip counter.
// Depends on png_pkg for types, register map and tap table.

// Produces one PN chip per input beat, one beat per clock while the output
// drains. Each accepted beat advances a 17-stage XNOR-feedback shift register
// whose taps and period (2^n-1 chips, one chip for code 1) follow the
// code_number register; a beat with restart_i set clears the register and
// chip counter before stepping, so its chip is 1. The result appears on the
// output channel the cycle after the input beat, held in one output register;
// the input side stays ready while that register is empty or being drained,
// so the sustained rate is one chip per cycle while the output drains.
// Write the config registers only while no beat is in flight.
module pn_code_generator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [png_pkg::AddrW-1:0] paddr,
  input  logic [png_pkg::DataW-1:0] pwdata,
  output logic [png_pkg::DataW-1:0] prdata,
  output logic                     pready,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     restart_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     chip_bit_o,
  output logic signed [31:0]       chip_value_o,
  output logic                     period_end_o
);

  png_pkg::code_t  code_q;
  png_pkg::data_t  low_q, high_q;
  png_pkg::stage_t stages_q, stages_d;
  png_pkg::stage_t count_q, count_d;
  png_pkg::stage_t stages_base, count_base;
  png_pkg::code_t  code_eff;
  logic            wr_en, in_fire;
  logic            bit_d, last_d;
  logic            out_valid_q;
  logic            chip_bit_q, period_end_q;
  png_pkg::data_t  chip_value_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= png_pkg::CodeReset;
      low_q  <= png_pkg::LowReset;
      high_q <= png_pkg::HighReset;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        png_pkg::RegCodeNumber: code_q <= pwdata[png_pkg::CodeW-1:0];
        png_pkg::RegLowValue:   low_q  <= pwdata;
        png_pkg::RegHighValue:  high_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back config registers
  always_comb begin
    unique case (paddr[3:2])
      png_pkg::RegCodeNumber:
        prdata = {{(png_pkg::DataW-png_pkg::CodeW){1'b0}}, code_q};
      png_pkg::RegLowValue:  prdata = low_q;
      png_pkg::RegHighValue: prdata = high_q;
      default:               prdata = '0;
    endcase
  end

  // Accept while the output register is free or draining
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // Step the shift register and chip counter
  always_comb begin
    code_eff    = png_pkg::eff_code(code_q);
    stages_base = restart_i ? '0 : stages_q;
    count_base  = restart_i ? '0 : count_q;
    bit_d       = ~(^(stages_base & png_pkg::tap_mask(code_eff)));
    stages_d    = {stages_base[png_pkg::MaxStages-2:0], bit_d};
    last_d      = (count_base >= png_pkg::last_index(code_eff));
    count_d     = last_d ? '0 : count_base + png_pkg::stage_t'(1);
  end

  // Hold generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= '0;
      count_q  <= '0;
    end else if (in_fire) begin
      stages_q <= stages_d;
      count_q  <= count_d;
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chip_bit_q   <= bit_d;
      chip_value_q <= bit_d ? high_q : low_q;
      period_end_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chip_bit_o   = chip_bit_q;
  assign chip_value_o = chip_value_q;
  assign period_end_o = period_end_q;

endmodule

// ===== rtl/core/png_checker.sv =====
// Port-level checker for the PN code generator, bound to the top level.
// Depends on pn_code_generator_macros.svh for the assertion macros.
`include "pn_code_generator_macros.svh"

module png_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        restart_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        chip_bit_o,
  input logic [31:0] chip_value_o,
  input logic        period_end_o
);

  // A stalled result beat holds its payload
  `PNG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(chip_bit_o) && $stable(chip_value_o) && $stable(period_end_o), "stalled result beat changed")

  // Every input beat yields a result beat the next cycle
  `PNG_ASSERT_NEXT(a_beat_result, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "input beat without result")

  // An empty output register never blocks the input
  `PNG_ASSERT_NOW(a_no_stall, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")

  // Restart steps from the all-zero state, so the chip is one
  `PNG_ASSERT_NEXT(a_restart_chip, clk_i, rst_ni, in_valid_i && in_ready_o && restart_i, chip_bit_o, "restart chip not one")

endmodule

bind pn_code_generator png_checker u_png_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .restart_i    (restart_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .chip_bit_o   (chip_bit_o),
  .chip_value_o (chip_value_o),
  .period_end_o (period_end_o)
);
